[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every rising edge outside reset
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

[src/mec_pkg.sv]
// ----------------------------------------------------------------------------
// mec_pkg
// types and constants for the escape count core
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  localparam int FRACTION_BITS = 28;

  localparam int Z_W   = 32;          // width of z and c components
  localparam int P_W   = 2 * Z_W;     // full product width
  localparam int L_W   = P_W + 2;     // headroom for sums of shifted products
  localparam int CNT_W = 9;

  localparam logic [CNT_W-1:0] ITER_CAP = CNT_W'(256);

  // 4.0 at the working scale
  localparam logic signed [L_W-1:0] FOUR = L_W'(1) << (FRACTION_BITS + 2);

  localparam logic signed [L_W-1:0] Z_MAX = {{(L_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
  localparam logic signed [L_W-1:0] Z_MIN = {{(L_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[src/mandelbrot_escape_count_core.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_core
// escape-time iteration counter for one complex point per transfer
// ----------------------------------------------------------------------------
// usage
//   s_* carries point c (two signed Q4.28 words), m_* returns the iteration
//   count. cfg_wen/cfg_wdata set the iteration limit (0 acts as 1, values
//   above 256 act as 256); write it only while the core is idle.
// operation
//   each iteration runs on one shared multiplier set: in ST_MUL three
//   32x32 products are registered, then in ST_ADD they are shifted, added,
//   saturated and the escape test is made. s_tready is high only while
//   idle, and one point is in work at a time.
// stall
//   the result sits in an output register; a new point may be taken while
//   it waits. a finished count then holds until the register is free.
// reset
//   rst is synchronous: the core goes idle, the output is emptied and the
//   limit returns to 256.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mandelbrot_escape_count_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // c_real [31:0], c_imag [63:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // escape_count [8:0], zero [15:9]
);

  localparam int ZW = mec_pkg::Z_W;
  localparam int PW = mec_pkg::P_W;
  localparam int LW = mec_pkg::L_W;
  localparam int CW = mec_pkg::CNT_W;
  localparam int F  = mec_pkg::FRACTION_BITS;

  mec_pkg::state_t state, state_next;

  logic [CW-1:0]          max_iterations;
  logic [CW-1:0]          limit;
  logic [CW-1:0]          count;
  logic signed [ZW-1:0]   c_real, c_imag;
  logic signed [ZW-1:0]   zr, zi;
  logic signed [PW-1:0]   p_rr, p_ii, p_ri;
  logic [CW-1:0]          escape_count;

  logic                   in_xfer;
  logic                   out_load;
  logic                   iter_done;
  logic                   escaped;
  logic signed [LW-1:0]   rr, ii, ri2, lsq, nr, ni;
  logic signed [ZW-1:0]   zr_next, zi_next;
  logic [CW-1:0]          limit_next;

  // shifted products, floor rounding by arithmetic shift
  assign rr  = LW'(p_rr >>> F);
  assign ii  = LW'(p_ii >>> F);
  assign ri2 = LW'(p_ri >>> (F - 1));
  assign lsq = rr + ii;
  assign nr  = rr - ii + LW'(c_real);
  assign ni  = ri2 + LW'(c_imag);

  always_comb begin
    if (nr > mec_pkg::Z_MAX) begin
      zr_next = ZW'(mec_pkg::Z_MAX);
    end else if (nr < mec_pkg::Z_MIN) begin
      zr_next = ZW'(mec_pkg::Z_MIN);
    end else begin
      zr_next = ZW'(nr);
    end
    if (ni > mec_pkg::Z_MAX) begin
      zi_next = ZW'(mec_pkg::Z_MAX);
    end else if (ni < mec_pkg::Z_MIN) begin
      zi_next = ZW'(mec_pkg::Z_MIN);
    end else begin
      zi_next = ZW'(ni);
    end
  end

  // escape test on the current z, which is the new z of the last iteration
  assign escaped   = (count != '0) && (lsq >= mec_pkg::FOUR);
  assign iter_done = escaped || (count == limit);

  always_comb begin
    if (max_iterations == '0) begin
      limit_next = CW'(1);
    end else if (max_iterations > mec_pkg::ITER_CAP) begin
      limit_next = mec_pkg::ITER_CAP;
    end else begin
      limit_next = max_iterations;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mec_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = mec_pkg::ST_MUL;
      end
      mec_pkg::ST_MUL: begin
        state_next = mec_pkg::ST_ADD;
      end
      mec_pkg::ST_ADD: begin
        state_next = iter_done ? mec_pkg::ST_DONE : mec_pkg::ST_MUL;
      end
      mec_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = mec_pkg::ST_IDLE;
      end
      default: state_next = mec_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      mec_pkg::ST_IDLE: s_tready = 1'b1;
      mec_pkg::ST_DONE: out_load = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_xfer = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mec_pkg::ST_IDLE;
      m_tvalid       <= 1'b0;
      max_iterations <= mec_pkg::ITER_CAP;
    end else begin
      state <= state_next;
      if (cfg_wen) max_iterations <= cfg_wdata;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      c_real <= s_tdata[31:0];
      c_imag <= s_tdata[63:32];
      zr     <= '0;
      zi     <= '0;
      count  <= '0;
      limit  <= limit_next;
    end
    if (state == mec_pkg::ST_MUL) begin
      p_rr <= PW'(zr) * PW'(zr);
      p_ii <= PW'(zi) * PW'(zi);
      p_ri <= PW'(zr) * PW'(zi);
    end
    if (state == mec_pkg::ST_ADD && !iter_done) begin
      zr    <= zr_next;
      zi    <= zi_next;
      count <= count + CW'(1);
    end
    if (out_load) escape_count <= count;
  end

  assign m_tdata = {{(16-CW){1'b0}}, escape_count};

  `ASSERT_SYNC(a_start_clean, clk, rst,
    in_xfer |=> (state == mec_pkg::ST_MUL) && (count == '0), "point did not start at zero")
  `ASSERT_NEVER(a_count_bound, clk, rst,
    (state != mec_pkg::ST_IDLE) && (count > limit), "iteration count passed the limit")
  `ASSERT_NEVER(a_limit_range, clk, rst,
    (state != mec_pkg::ST_IDLE) && ((limit == '0) || (limit > mec_pkg::ITER_CAP)),
    "effective limit out of range")
  `ASSERT_NEVER(a_result_range, clk, rst,
    m_tvalid && ((escape_count == '0) || (escape_count > mec_pkg::ITER_CAP)),
    "escape count out of range")

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for mandelbrot_escape_count_core: points go in on the
// s_ stream and counts come back on the m_ stream. each accepted point has its
// count queued, typed in or from a local fixed-point escape-time predictor at
// the current limit, and checked in order as they return. the limit changes
// between phases; stalls are random on both sides, plus one long rx hold-off.
// ----------------------------------------------------------------------------

module tb;

  localparam int  CYCLE_LIMIT   = 2_000_000;
  localparam int  PHASE_POINTS  = 92;
  localparam int  HOLD_AT       = 150;    // receiver transfers before the long hold-off
  localparam int  HOLD_CYCLES   = 2000;
  localparam int  TAIL_CYCLES   = 600;    // idle wait after the final drain
  localparam int  N_DIRECTED    = 19;
  localparam int  N_PHASES      = 6;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -WORD_MAX - 1;

  typedef struct packed {
    logic [31:0] c_real;
    logic [31:0] c_imag;
    logic        known;     // count typed in below
    logic [8:0]  count;
  } point_row_t;

  typedef struct packed {
    logic [31:0] c_real;
    logic [31:0] c_imag;
    logic [8:0]  count;
  } escape_entry_t;

  // Q4.28: 1.0 = 32'h1000_0000
  point_row_t directed_points [N_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 9'd256},  // origin, stays at zero
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 9'd1},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 9'd1},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 9'd1},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 9'd1},
    '{32'hE000_0000, 32'h0000_0000, 1'b1, 9'd1},    // -2.0, |z|^2 exactly 4
    '{32'h2000_0000, 32'h0000_0000, 1'b1, 9'd1},    // 2.0
    '{32'h1000_0000, 32'h0000_0000, 1'b1, 9'd2},    // 1.0 then 2.0
    '{32'hF000_0000, 32'h0000_0000, 1'b1, 9'd256},  // -1.0, period two
    '{32'h0400_0000, 32'h0000_0000, 1'b0, 9'd0},    // cusp at 0.25
    '{32'h1FFF_FFFF, 32'h0000_0000, 1'b0, 9'd0},    // one lsb under 2.0
    '{32'h0000_0000, 32'h1FFF_FFFF, 1'b0, 9'd0},
    '{32'h0000_0000, 32'h1000_0000, 1'b0, 9'd0},    // c = i
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 9'd0},
    '{32'h0000_0001, 32'h0000_0001, 1'b0, 9'd0},
    '{32'h0800_0000, 32'h0000_0000, 1'b0, 9'd0},
    '{32'hF400_0000, 32'h0199_999A, 1'b0, 9'd0},    // neck, slow escape
    '{32'hE000_0000, 32'h0000_0001, 1'b0, 9'd0},
    '{32'h1000_0000, 32'h1000_0000, 1'b0, 9'd0}
  };

  logic [8:0] phase_limits [N_PHASES] = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd37, 9'd256};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wen   = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;

  escape_entry_t pending_counts [$];
  logic [8:0]    limit_reg      = mec_pkg::ITER_CAP;
  int            mismatch_count = 0;
  int            send_idle_pct  = 30;
  int            recv_idle_pct  = 63;
  int            cycle_count    = 0;
  int            rx_transfers   = 0;
  int            hold_left      = 0;
  bit            hold_done      = 1'b0;

  mandelbrot_escape_count_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // z = z*z + c from zero, products floored back to scale, until |z|^2 >= 4 or the limit
  function automatic logic [8:0] escape_count_of(input logic signed [31:0] cr,
                                                 input logic signed [31:0] ci,
                                                 input logic [8:0] lim_reg);
    longint zr, zi, rr, ii, ri2, nr, mag, four;
    int     lim, n;
    bit     escaped;
    four    = longint'(1) << (mec_pkg::FRACTION_BITS + 2);
    lim     = (lim_reg == 0) ? 1 :
              (lim_reg > mec_pkg::ITER_CAP) ? int'(mec_pkg::ITER_CAP) : int'(lim_reg);
    zr      = 0;
    zi      = 0;
    n       = 0;
    escaped = 1'b0;
    while (!escaped && n < lim) begin
      rr  = (zr * zr) >>> mec_pkg::FRACTION_BITS;
      ii  = (zi * zi) >>> mec_pkg::FRACTION_BITS;
      ri2 = (zr * zi) >>> (mec_pkg::FRACTION_BITS - 1);
      nr  = sat_word(rr - ii + longint'(cr));
      zi  = sat_word(ri2 + longint'(ci));
      zr  = nr;
      n++;
      mag = ((zr * zr) >>> mec_pkg::FRACTION_BITS) + ((zi * zi) >>> mec_pkg::FRACTION_BITS);
      if (mag >= four) escaped = 1'b1;
    end
    return 9'(n);
  endfunction

  task automatic report(input string what, input escape_entry_t want, input logic [8:0] got);
    mismatch_count++;
    $display("%0t  %s: c = %h + %h i, expected %0d, got %0d",
             $time, what, want.c_real, want.c_imag, want.count, got);
  endtask

  task automatic send_point(input logic [31:0] re, input logic [31:0] im,
                            input logic known, input logic [8:0] typed_count);
    escape_entry_t e;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {im, re};
    do @(posedge clk); while (!s_tready);
    e.c_real = re;
    e.c_imag = im;
    e.count  = known ? typed_count : escape_count_of(re, im, limit_reg);
    pending_counts.push_back(e);
  endtask

  // sender pauses until every queued count has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_counts.size() != 0);
  endtask

  // receiver: random stalls plus one long hold-off so the core backs up
  always @(posedge clk) begin
    if (m_tvalid && m_tready) rx_transfers++;
    if (!hold_done && rx_transfers == HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    escape_entry_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_counts.size() == 0) begin
        want = '0;
        report("unexpected result transfer", want, m_tdata[8:0]);
      end else begin
        want = pending_counts.pop_front();
        if (m_tdata[8:0] !== want.count) report("escape_count mismatch", want, m_tdata[8:0]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] re, im;
    int          sel;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_points[i])
      send_point(directed_points[i].c_real, directed_points[i].c_imag,
                 directed_points[i].known, directed_points[i].count);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= phase_limits[p];
        @(posedge clk);
        cfg_wen   <= 1'b0;
        limit_reg = phase_limits[p];
      end
      if (p < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 63;
      end else if (p < 4) begin
        send_idle_pct = 63;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (PHASE_POINTS) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
          // anywhere in the word range, mostly instant escapes
          re = $urandom;
          im = $urandom;
        end else begin
          // window over the set: real -2.0 .. 0.6, imag -1.25 .. 1.25
          re = 32'hE000_0000 + $urandom_range(0, 32'h2999_9999);
          im = 32'hEC00_0000 + $urandom_range(0, 32'h2800_0000);
        end
        send_point(re, im, 1'b0, 9'd0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
